// ----- rtl/mie_pkg.sv -----
// ----------------------------------------------------------------------------
// mie_pkg: shared types and constants for the modular inverse block
// Widths, reset modulus, sequencer states and the divider command/status
// structs used between the sequencer and the shared divide unit.
// ----------------------------------------------------------------------------
package mie_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned CntWidth  = $clog2(DataWidth);

   // Default modulus: 2^64 - 2^32 + 1
   localparam logic [DataWidth-1:0] ModulusReset = 64'hFFFF_FFFF_0000_0001;

   localparam logic [CntWidth-1:0] LastStep = CntWidth'(DataWidth - 1);

   typedef logic [DataWidth-1:0] data_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_INIT,
      ST_STEP_A,
      ST_STEP_B,
      ST_FINISH
   } state_type;

   // Command to the divide unit: remainder of dividend/divisor and
   // cofactor base + quotient * mult.
   typedef struct packed {
      logic     start;
      data_type dividend;
      data_type divisor;
      data_type mult;
      data_type base;
   } div_cmd_type;

   typedef struct packed {
      logic     done;
      data_type rem;
      data_type cof;
   } div_stat_type;

endpackage

// ----- rtl/mie_if.sv -----
// ----------------------------------------------------------------------------
// mie_req_if / mie_rsp_if: valid/ready channels of the modular inverse block
// One word moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
interface mie_req_if;
   logic               valid;
   logic               ready;
   mie_pkg::data_type  value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface mie_rsp_if;
   logic               valid;
   logic               ready;
   mie_pkg::data_type  inverse;

   modport source (output valid, output inverse, input ready);
   modport sink   (input valid, input inverse, output ready);
endinterface

// ----- rtl/mie_div_unit.sv -----
// ----------------------------------------------------------------------------
// mie_div_unit: shared radix-2 restoring divider with cofactor accumulate
// Produces dividend % divisor and base + (dividend / divisor) * mult, one
// quotient bit per cycle; the product is built MSB-first by shift and add.
// ----------------------------------------------------------------------------
module mie_div_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  mie_pkg::div_cmd_type  cmd,
   output mie_pkg::div_stat_type stat
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [mie_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   mie_pkg::data_type            num_ff, num_in;
   mie_pkg::data_type            den_ff, den_in;
   mie_pkg::data_type            mult_ff, mult_in;
   mie_pkg::data_type            base_ff, base_in;
   mie_pkg::data_type            rem_ff, rem_in;
   mie_pkg::data_type            prod_ff, prod_in;

   logic [mie_pkg::DataWidth:0]  shifted;
   logic [mie_pkg::DataWidth:0]  diff;
   logic                         fits;

   // trial subtract of the divisor from the shifted partial remainder
   always_comb begin
      shifted = {rem_ff, num_ff[mie_pkg::DataWidth-1]};
      diff    = shifted - {1'b0, den_ff};
      fits    = ~diff[mie_pkg::DataWidth];
   end

   // next state of the iteration
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      mult_in = mult_ff;
      base_in = base_ff;
      rem_in  = rem_ff;
      prod_in = prod_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = cmd.dividend;
         den_in  = cmd.divisor;
         mult_in = cmd.mult;
         base_in = cmd.base;
         rem_in  = '0;
         prod_in = '0;
      end else if (busy_ff) begin
         num_in  = {num_ff[mie_pkg::DataWidth-2:0], 1'b0};
         rem_in  = fits ? diff[mie_pkg::DataWidth-1:0] : shifted[mie_pkg::DataWidth-1:0];
         prod_in = {prod_ff[mie_pkg::DataWidth-2:0], 1'b0} + (fits ? mult_ff : '0);
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == mie_pkg::LastStep) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      mult_ff <= mult_in;
      base_ff <= base_in;
      rem_ff  <= rem_in;
      prod_ff <= prod_in;
   end

   assign stat.done = done_ff;
   assign stat.rem  = rem_ff;
   assign stat.cof  = base_ff + prod_ff;

endmodule

// ----- rtl/modular_inverse_euclid_top.sv -----
// ----------------------------------------------------------------------------
// modular_inverse_euclid_top: modular inverse by extended Euclid
// Inverts a 64-bit word modulo the csr modulus with one shared divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan (sink) takes one 64-bit value word; rsp_chan (source) returns
//   one inverse word per request, 0 when no inverse exists or the residue
//   is zero. csr_we/csr_wdata write the modulus; write only while idle.
// Sequence: every divide in the shared unit works through 64 quotient
//   bits. A request takes one reduction, one setup divide and k Euclid
//   divides, with k up to about 90 for 64-bit operands. A zero residue
//   skips the setup and Euclid divides; a modulus below 2 needs no divide.
// Throughput: one request at a time; req_ready is high only while the
//   sequencer is idle and returns with the result word.
// Reset: synchronous, active high; modulus returns to 2^64 - 2^32 + 1,
//   the sequencer goes idle and the output register empties.
// Stall: a finished word waits in the output register. A new request is
//   accepted meanwhile; its result waits in the sequencer until the
//   output register frees.
// ----------------------------------------------------------------------------
module modular_inverse_euclid_top (
   input  logic              clock,
   input  logic              reset,
   mie_req_if.sink           req_chan,
   mie_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  mie_pkg::data_type csr_wdata
);

   mie_pkg::state_type    state_ff, state_in;
   mie_pkg::data_type     modulus_ff;
   mie_pkg::data_type     ra_ff, ra_in;
   mie_pkg::data_type     ca_ff, ca_in;
   mie_pkg::data_type     rb_ff, rb_in;
   mie_pkg::data_type     cb_ff, cb_in;
   mie_pkg::data_type     res_ff, res_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mie_pkg::data_type     rsp_data_ff, rsp_data_in;

   mie_pkg::div_cmd_type  div_cmd;
   mie_pkg::div_stat_type div_stat;

   logic                  out_free;

   mie_div_unit u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .stat  (div_stat)
   );

   assign out_free       = ~rsp_valid_ff | rsp_chan.ready;
   assign req_chan.ready = (state_ff == mie_pkg::ST_IDLE);
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.inverse = rsp_data_ff;

   // sequencer: next state, pair updates and divider commands
   always_comb begin
      state_in     = state_ff;
      ra_in        = ra_ff;
      ca_in        = ca_ff;
      rb_in        = rb_ff;
      cb_in        = cb_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_data_in  = rsp_data_ff;
      div_cmd      = '0;
      unique case (state_ff)
         mie_pkg::ST_IDLE: begin
            if (req_chan.valid) begin
               if (modulus_ff < mie_pkg::DataWidth'(2)) begin
                  res_in   = '0;
                  state_in = mie_pkg::ST_FINISH;
               end else begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = req_chan.value;
                  div_cmd.divisor  = modulus_ff;
                  state_in         = mie_pkg::ST_REDUCE;
               end
            end
         end
         mie_pkg::ST_REDUCE: begin
            if (div_stat.done) begin
               ra_in = div_stat.rem;
               ca_in = mie_pkg::DataWidth'(1);
               if (div_stat.rem == '0) begin
                  res_in   = '0;
                  state_in = mie_pkg::ST_FINISH;
               end else begin
                  // rb = m % ra, cb = m / ra
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = modulus_ff;
                  div_cmd.divisor  = div_stat.rem;
                  div_cmd.mult     = mie_pkg::DataWidth'(1);
                  state_in         = mie_pkg::ST_INIT;
               end
            end
         end
         mie_pkg::ST_INIT, mie_pkg::ST_STEP_B: begin
            if (div_stat.done) begin
               rb_in = div_stat.rem;
               cb_in = div_stat.cof;
               if (div_stat.rem == '0) begin
                  res_in   = (ra_ff == mie_pkg::DataWidth'(1)) ? ca_ff : '0;
                  state_in = mie_pkg::ST_FINISH;
               end else begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = ra_ff;
                  div_cmd.divisor  = div_stat.rem;
                  div_cmd.mult     = div_stat.cof;
                  div_cmd.base     = ca_ff;
                  state_in         = mie_pkg::ST_STEP_A;
               end
            end
         end
         mie_pkg::ST_STEP_A: begin
            if (div_stat.done) begin
               ra_in = div_stat.rem;
               ca_in = div_stat.cof;
               if (div_stat.rem == '0) begin
                  res_in   = (rb_ff == mie_pkg::DataWidth'(1)) ? (modulus_ff - cb_ff) : '0;
                  state_in = mie_pkg::ST_FINISH;
               end else begin
                  div_cmd.start    = 1'b1;
                  div_cmd.dividend = rb_ff;
                  div_cmd.divisor  = div_stat.rem;
                  div_cmd.mult     = div_stat.cof;
                  div_cmd.base     = cb_ff;
                  state_in         = mie_pkg::ST_STEP_B;
               end
            end
         end
         mie_pkg::ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = mie_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mie_pkg::ST_IDLE;
         end
      endcase
   end

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mie_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= mie_pkg::ModulusReset;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            modulus_ff <= csr_wdata;
         end
      end
   end

   // working pairs and result registers
   always_ff @(posedge clock) begin
      ra_ff       <= ra_in;
      ca_ff       <= ca_in;
      rb_ff       <= rb_in;
      cb_ff       <= cb_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- rtl/mie_checker.sv -----
// ----------------------------------------------------------------------------
// mie_checker: port-level checks for the modular inverse block
// Watches the top-level handshakes over time; bound into the top level.
// ----------------------------------------------------------------------------
module mie_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mie_pkg::data_type rsp_inverse
);

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inverse))
      else $error("stalled result word changed");

   // after reset the block is idle with an empty output
   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not idle after reset");

   // an accepted request makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");

   // a new result is loaded only as the sequencer returns to idle
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result appeared while sequencer busy");

endmodule

bind modular_inverse_euclid_top mie_checker u_mie_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_inverse (rsp_chan.inverse)
);
